### src/mesh_color_last_point_finder_assert.svh
// Assertion helpers for the last-point finder.
`ifndef MESH_COLOR_LAST_POINT_FINDER_ASSERT_SVH
`define MESH_COLOR_LAST_POINT_FINDER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MCLPF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, checked at every rising edge outside reset.
`define MCLPF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

### src/mclpf_pkg.sv
`timescale 1ns / 1ps
package mclpf_pkg;

  localparam int POINTS_DEF      = 4096;
  localparam int DEGREE_BITS_DEF = 8;

  localparam int PT_W    = 12;
  localparam int CPTS_W  = 13;
  localparam int CNUM_W  = 16;

  localparam logic [CPTS_W-1:0] CPTS_MAX = {CPTS_W{1'b1}};
  localparam logic [CNUM_W-1:0] CNUM_MAX = {CNUM_W{1'b1}};

  localparam logic MODE_COUNT = 1'b0;
  localparam logic MODE_FINAL = 1'b1;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // sequencer to counter store
  typedef struct packed {
    logic rd;    // read the entry at addr into the data register
    logic upd;   // update and write back the entry read last
    logic mode;  // pass of the update
  } store_cmd_t;

  // counter store to sequencer
  typedef struct packed {
    logic ready; // clearing pass finished
    logic fin;   // this update finalised the point
  } store_sts_t;

endpackage

### src/mclpf_store.sv
`timescale 1ns / 1ps
module mclpf_store import mclpf_pkg::*; #(
  parameter int POINTS      = POINTS_DEF,
  parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  store_cmd_t                cmd,
  input  logic [$clog2(POINTS)-1:0] addr,
  output store_sts_t                sts
);

  localparam int AW = $clog2(POINTS);
  localparam int DB = DEGREE_BITS;
  localparam logic [DB-1:0] CNT_MAX = {DB{1'b1}};

  // entry word: degree in the upper half, seen count in the lower half
  logic [2*DB-1:0] mem [POINTS];
  logic [2*DB-1:0] rdata_r;
  logic [AW-1:0]   addr_r;
  logic [AW-1:0]   clr_addr_r;
  logic            clr_busy_r;

  logic [DB-1:0]   deg, seen, deg_inc, seen_inc;
  logic            fin;
  logic [2*DB-1:0] upd_word, wword;
  logic [AW-1:0]   waddr;
  logic            we;

  // shared update unit: saturating increment, compare against degree
  always_comb begin
    deg      = rdata_r[2*DB-1:DB];
    seen     = rdata_r[DB-1:0];
    deg_inc  = (deg == CNT_MAX) ? deg : deg + DB'(1);
    seen_inc = (seen == CNT_MAX) ? seen : seen + DB'(1);
    fin      = (cmd.mode == MODE_FINAL) && (seen_inc == deg);
    if (cmd.mode == MODE_FINAL) begin
      upd_word = fin ? '0 : {deg, seen_inc};
    end else begin
      upd_word = {deg_inc, seen};
    end
    we    = clr_busy_r | cmd.upd;
    waddr = clr_busy_r ? clr_addr_r : addr_r;
    wword = clr_busy_r ? '0 : upd_word;
  end

  assign sts.ready = !clr_busy_r;
  assign sts.fin   = cmd.upd & fin;

  // clearing pass after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == AW'(POINTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wword;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
      addr_r  <= addr;
    end
  end

endmodule

### src/mesh_color_last_point_finder.sv
`timescale 1ns / 1ps
// Mesh colour last-point finder. Each item is one face with two endpoint indices;
// mode 0 counts each endpoint into its stored degree, mode 1 replays the faces and
// bumps each endpoint's seen count, first endpoint before second, emitting the point
// (kind 0) when its seen count reaches its degree and then clearing both its
// counters. With color_end set in mode 1 a colour summary (kind 1) follows with
// the colour's finalised point count and its number; the last result of an item
// carries last. Counters saturate; endpoints not below POINTS are ignored. Both
// counters of a point share one word in a single-port memory, so every endpoint in
// range takes a read and then a write-back through the one update unit, while an
// endpoint out of range is neither read nor written. An item passes through the take
// in idle, a read state per endpoint, a write state per endpoint in range, and the
// emit state, which hands out its results in order as the output slot frees, and
// in_stall stays high meanwhile. After reset a clearing pass zeroes the memory; no
// item is taken until it ends.
`include "mesh_color_last_point_finder_assert.svh"
module mesh_color_last_point_finder import mclpf_pkg::*; #(
  parameter int POINTS      = POINTS_DEF,
  parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [PT_W-1:0]   in_point_a,
  input  logic [PT_W-1:0]   in_point_b,
  input  logic              in_color_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [PT_W-1:0]   out_point,
  output logic [CPTS_W-1:0] out_color_points,
  output logic [CNUM_W-1:0] out_color_number,
  output logic              out_last
);

  localparam int AW    = $clog2(POINTS);
  localparam int EXT_W = ((AW > PT_W) ? AW : PT_W) + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_A, ST_WR_A, ST_RD_B, ST_WR_B, ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic              mode_r, cend_r;
  logic [PT_W-1:0]   pa_r, pb_r;
  logic              pend_a_r, pend_a_nxt;
  logic              pend_b_r, pend_b_nxt;
  logic              pend_s_r, pend_s_nxt;
  logic [CPTS_W-1:0] pic_r, pic_nxt;
  logic [CNUM_W-1:0] color_r, color_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [PT_W-1:0]   out_point_r, out_point_nxt;
  logic [CPTS_W-1:0] out_cpts_r, out_cpts_nxt;
  logic [CNUM_W-1:0] out_cnum_r, out_cnum_nxt;
  logic              out_last_r, out_last_nxt;

  logic [EXT_W-1:0]  ext_a, ext_b;
  logic              ok_a, ok_b;
  logic              in_acc, slot_free;
  store_cmd_t        store_cmd;
  store_sts_t        store_sts;
  logic [AW-1:0]     store_addr;

  // endpoint range check, widened so any POINTS compares correctly
  assign ext_a = EXT_W'(pa_r);
  assign ext_b = EXT_W'(pb_r);
  assign ok_a  = ext_a < EXT_W'(POINTS);
  assign ok_b  = ext_b < EXT_W'(POINTS);

  assign in_stall  = !((state_r == ST_IDLE) && store_sts.ready);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign store_addr = (state_r == ST_RD_A) ? ext_a[AW-1:0] : ext_b[AW-1:0];

  always_comb begin
    store_cmd.rd   = (state_r == ST_RD_A && ok_a) || (state_r == ST_RD_B && ok_b);
    store_cmd.upd  = (state_r == ST_WR_A) || (state_r == ST_WR_B);
    store_cmd.mode = mode_r;
  end

  mclpf_store #(
    .POINTS      (POINTS),
    .DEGREE_BITS (DEGREE_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (store_cmd),
    .addr  (store_addr),
    .sts   (store_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    pend_a_nxt    = pend_a_r;
    pend_b_nxt    = pend_b_r;
    pend_s_nxt    = pend_s_r;
    pic_nxt       = pic_r;
    color_nxt     = color_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_point_nxt = out_point_r;
    out_cpts_nxt  = out_cpts_r;
    out_cnum_nxt  = out_cnum_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt  = ST_RD_A;
          pend_a_nxt = 1'b0;
          pend_b_nxt = 1'b0;
          pend_s_nxt = (in_mode == MODE_FINAL) && in_color_end;
        end
      end
      ST_RD_A: begin
        state_nxt = ok_a ? ST_WR_A : ST_RD_B;
      end
      ST_WR_A, ST_WR_B: begin
        // count the point into its colour as soon as it finalises
        if (store_sts.fin && pic_r != CPTS_MAX) begin
          pic_nxt = pic_r + CPTS_W'(1);
        end
        if (state_r == ST_WR_A) begin
          pend_a_nxt = store_sts.fin;
          state_nxt  = ST_RD_B;
        end else begin
          pend_b_nxt = store_sts.fin;
          state_nxt  = ST_EMIT;
        end
      end
      ST_RD_B: begin
        state_nxt = ok_b ? ST_WR_B : ST_EMIT;
      end
      ST_EMIT: begin
        if (!pend_a_r && !pend_b_r && !pend_s_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          // hand out the pending results in order, one per free slot
          out_valid_nxt = 1'b1;
          out_cpts_nxt  = '0;
          out_cnum_nxt  = '0;
          if (pend_a_r) begin
            out_kind_nxt  = KIND_POINT;
            out_point_nxt = pa_r;
            out_last_nxt  = !pend_b_r && !pend_s_r;
            pend_a_nxt    = 1'b0;
            if (!pend_b_r && !pend_s_r) begin
              state_nxt = ST_IDLE;
            end
          end else if (pend_b_r) begin
            out_kind_nxt  = KIND_POINT;
            out_point_nxt = pb_r;
            out_last_nxt  = !pend_s_r;
            pend_b_nxt    = 1'b0;
            if (!pend_s_r) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_kind_nxt  = KIND_SUMMARY;
            out_point_nxt = '0;
            out_cpts_nxt  = pic_r;
            out_cnum_nxt  = color_r;
            out_last_nxt  = 1'b1;
            pend_s_nxt    = 1'b0;
            pic_nxt       = '0;
            if (color_r != CNUM_MAX) begin
              color_nxt = color_r + CNUM_W'(1);
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_a_r    <= 1'b0;
      pend_b_r    <= 1'b0;
      pend_s_r    <= 1'b0;
      pic_r       <= '0;
      color_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_a_r    <= pend_a_nxt;
      pend_b_r    <= pend_b_nxt;
      pend_s_r    <= pend_s_nxt;
      pic_r       <= pic_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r  <= out_kind_nxt;
    out_point_r <= out_point_nxt;
    out_cpts_r  <= out_cpts_nxt;
    out_cnum_r  <= out_cnum_nxt;
    out_last_r  <= out_last_nxt;
    if (in_acc) begin
      mode_r <= in_mode;
      pa_r   <= in_point_a;
      pb_r   <= in_point_b;
      cend_r <= in_color_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_point        = out_point_r;
  assign out_color_points = out_cpts_r;
  assign out_color_number = out_cnum_r;
  assign out_last         = out_last_r;

  // a summary is only ever owed for a finalise-pass face that closes its colour
  `MCLPF_ASSERT_NOW(a_sum_owed, pend_s_r && state_r != ST_IDLE, mode_r && cend_r)
  // every item's results are all handed out before the next item is taken
  `MCLPF_ASSERT_NOW(a_idle_clean, state_r == ST_IDLE, !pend_a_r && !pend_b_r && !pend_s_r)
  // a colour summary always closes its item
  `MCLPF_ASSERT_NOW(a_sum_last, out_valid_r && out_kind_r == KIND_SUMMARY, out_last_r)
  // a read is always followed by the write-back of the same endpoint
  `MCLPF_ASSERT_NEXT(a_rd_then_upd, store_cmd.rd, store_cmd.upd)

endmodule

### tb/sv/mesh_color_last_point_finder_tb.sv
`timescale 1ns / 1ps
module mesh_color_last_point_finder_tb;
  import mclpf_pkg::*;

  // Longest quiet stretch of a correct run is the clearing pass after reset;
  // the receiver's long hold-off is the next longest.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 64;
  localparam int unsigned RANDOM_GOAL    = 40;
  localparam logic [PT_W-1:0] HOT_POINT  = 12'h5A5;

  typedef struct packed {
    logic            mode;
    logic [PT_W-1:0] pa;
    logic [PT_W-1:0] pb;
    logic            cend;
  } face_t;

  typedef struct packed {
    logic              kind;
    logic [PT_W-1:0]   point;
    logic [CPTS_W-1:0] cpts;
    logic [CNUM_W-1:0] cnum;
    logic              last;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = MODE_COUNT;
  logic [PT_W-1:0]   in_point_a = '0;
  logic [PT_W-1:0]   in_point_b = '0;
  logic              in_color_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic              out_kind;
  logic [PT_W-1:0]   out_point;
  logic [CPTS_W-1:0] out_color_points;
  logic [CNUM_W-1:0] out_color_number;
  logic              out_last;

  mesh_color_last_point_finder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_point_a       (in_point_a),
    .in_point_b       (in_point_b),
    .in_color_end     (in_color_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_point        (out_point),
    .out_color_points (out_color_points),
    .out_color_number (out_color_number),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Faces waiting to be offered, and results the block still owes us.
  face_t   pending_faces[$];
  result_t due_results[$];

  // Shadow of the block's counter store and colour registers.
  logic [DEGREE_BITS_DEF-1:0] degree_mem [POINTS_DEF];
  logic [DEGREE_BITS_DEF-1:0] seen_mem   [POINTS_DEF];
  logic [CPTS_W-1:0]          colour_pts = '0;
  logic [CNUM_W-1:0]          colour_no  = '0;

  // Handshake flags, set at the rising edge and read at the falling edge.
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;

  // Idling control: hold_req asks the receiver for one long hold-off.
  bit          hold_req = 1'b0;
  int unsigned tx_gap   = 0;
  int unsigned tx_calm  = 0;
  int unsigned rx_wait  = 0;
  int unsigned rx_calm  = 0;
  int unsigned rx_hold  = 0;

  int unsigned n_errors    = 0;
  int unsigned n_queued    = 0;
  int unsigned n_faces_in  = 0;
  int unsigned n_replayed  = 0;
  int unsigned n_points    = 0;
  int unsigned n_summaries = 0;
  int unsigned peak_cpts   = 0;
  int unsigned peak_cnum   = 0;
  int unsigned quiet_run   = 0;

  initial begin
    foreach (degree_mem[i]) begin
      degree_mem[i] = '0;
      seen_mem[i]   = '0;
    end
  end

  task automatic flag_error(string msg);
    n_errors++;
    $display("error: %s", msg);
  endtask

  // Count pass: add one to the degree, saturating.
  function automatic void add_degree(logic [PT_W-1:0] p);
    if (int'(p) >= POINTS_DEF) return;
    if (degree_mem[p] != '1) degree_mem[p] = degree_mem[p] + DEGREE_BITS_DEF'(1);
  endfunction

  // Finalise pass: bump the seen count, saturating; on reaching the degree,
  // clear both entries of the point and report it final.
  function automatic bit bump_seen(logic [PT_W-1:0] p);
    logic [DEGREE_BITS_DEF-1:0] s;
    if (int'(p) >= POINTS_DEF) return 1'b0;
    s = seen_mem[p];
    if (s != '1) s = s + DEGREE_BITS_DEF'(1);
    seen_mem[p] = s;
    if (s == degree_mem[p]) begin
      seen_mem[p]   = '0;
      degree_mem[p] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the results of one accepted face and queue them in order.
  task automatic predict_face(face_t f);
    result_t         r;
    result_t         batch[$];
    logic [PT_W-1:0] ends[2];
    ends[0] = f.pa;
    ends[1] = f.pb;
    if (f.mode == MODE_COUNT) begin
      // colour mark means nothing in the count pass
      add_degree(f.pa);
      add_degree(f.pb);
      return;
    end
    n_replayed++;
    for (int i = 0; i < 2; i++) begin
      if (bump_seen(ends[i])) begin
        r       = '0;
        r.kind  = KIND_POINT;
        r.point = ends[i];
        batch.push_back(r);
        if (colour_pts != CPTS_MAX) colour_pts = colour_pts + CPTS_W'(1);
      end
    end
    if (f.cend) begin
      r      = '0;
      r.kind = KIND_SUMMARY;
      r.cpts = colour_pts;
      r.cnum = colour_no;
      batch.push_back(r);
      colour_pts = '0;
      if (colour_no != CNUM_MAX) colour_no = colour_no + CNUM_W'(1);
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) due_results.push_back(batch[i]);
  endtask

  // Compare the result on the output ports with the oldest one owed.
  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      flag_error($sformatf("unexpected result kind %0d point %0d", out_kind, out_point));
      return;
    end
    want = due_results.pop_front();
    if (out_kind !== want.kind)
      flag_error($sformatf("kind %0d, want %0d", out_kind, want.kind));
    if (out_point !== want.point)
      flag_error($sformatf("point %0d, want %0d", out_point, want.point));
    if (out_color_points !== want.cpts)
      flag_error($sformatf("colour points %0d, want %0d", out_color_points, want.cpts));
    if (out_color_number !== want.cnum)
      flag_error($sformatf("colour number %0d, want %0d", out_color_number, want.cnum));
    if (out_last !== want.last)
      flag_error($sformatf("last %0d, want %0d", out_last, want.last));
    if (want.kind == KIND_SUMMARY) begin
      n_summaries++;
      if (32'(want.cpts) > peak_cpts) peak_cpts = 32'(want.cpts);
      if (32'(want.cnum) > peak_cnum) peak_cnum = 32'(want.cnum);
    end else begin
      n_points++;
    end
  endtask

  // Sample both channels at the rising edge: check outputs first, since they
  // can only stem from faces taken at earlier edges, then predict the new face.
  always @(posedge clk) begin : sample
    face_t f;
    in_taken  = rst_n && in_valid && !in_stall;
    out_taken = rst_n && (out_valid === 1'b1) && !out_stall;
    if (out_taken) check_result();
    if (in_taken) begin
      f.mode = in_mode;
      f.pa   = in_point_a;
      f.pb   = in_point_b;
      f.cend = in_color_end;
      n_faces_in++;
      predict_face(f);
    end
    // Watchdog: end the run once nothing has moved for too long.
    if (in_taken || out_taken) quiet_run = 0;
    else quiet_run++;
    if (quiet_run >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_run);
      $display("status: fail");
      $finish;
    end
  end

  // Draw the wait before the next item: now and then a calm run with no
  // idling at all, otherwise a random wait that may also be none.
  function automatic int unsigned draw_wait(inout int unsigned calm_run);
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      calm_run = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // Sender: hold a stalled item, idle out the gap, then offer the next face.
  always @(negedge clk) begin : sender
    face_t f;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the item until the block takes it
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap--;
    end else if (pending_faces.size() > 0) begin
      f = pending_faces.pop_front();
      in_valid     <= 1'b1;
      in_mode      <= f.mode;
      in_point_a   <= f.pa;
      in_point_b   <= f.pb;
      in_color_end <= f.cend;
      tx_gap = draw_wait(tx_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: a long hold-off when asked, otherwise stall each result for its
  // drawn wait (counted down only while a result is on offer).
  always @(negedge clk) begin
    if (out_taken) rx_wait = draw_wait(rx_calm);
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      rx_hold   = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (rx_wait > 0);
      if (rx_wait > 0 && out_valid === 1'b1) rx_wait--;
    end
  end

  task automatic push_face(logic mode, logic [PT_W-1:0] a, logic [PT_W-1:0] b, logic cend);
    face_t f;
    f.mode = mode;
    f.pa   = a;
    f.pb   = b;
    f.cend = cend;
    pending_faces.push_back(f);
    n_queued++;
  endtask

  // One set of colours: count every face, then replay them with the colour
  // marks. A broken set replays only a prefix and leaves points half seen.
  task automatic queue_colour_set(bit broken);
    face_t       set_faces[$];
    face_t       f;
    int unsigned n_col;
    int unsigned n_face;
    int unsigned base;
    int unsigned span;
    int unsigned cut;
    n_col = $urandom_range(1, 3);
    span  = $urandom_range(1, 15);
    base  = $urandom_range(0, 4095 - span);
    for (int c = 0; c < n_col; c++) begin
      n_face = $urandom_range(1, 5);
      for (int j = 0; j < n_face; j++) begin
        f.mode = MODE_FINAL;
        f.pa   = PT_W'(base + $urandom_range(0, span));
        f.pb   = PT_W'(base + $urandom_range(0, span));
        f.cend = (j == n_face - 1);
        set_faces.push_back(f);
      end
    end
    foreach (set_faces[i])
      push_face(MODE_COUNT, set_faces[i].pa, set_faces[i].pb, 1'($urandom_range(0, 1)));
    cut = broken ? $urandom_range(0, set_faces.size() - 1) : set_faces.size();
    for (int i = 0; i < cut; i++) begin
      pending_faces.push_back(set_faces[i]);
      n_queued++;
    end
  endtask

  task automatic wait_sent();
    while (pending_faces.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned half;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed faces: extreme indices, colour mark in the count pass, three
    // results from one face, the same endpoint twice (finalised by the second
    // update, or cleared by the first and counted afresh by the second),
    // points never counted, a summary with no points and a face with no result.
    push_face(MODE_COUNT, 12'd0, 12'd4095, 1'b1);
    push_face(MODE_COUNT, 12'd4095, 12'd0, 1'b0);
    push_face(MODE_FINAL, 12'd0, 12'd4095, 1'b0);
    push_face(MODE_FINAL, 12'd4095, 12'd0, 1'b1);
    push_face(MODE_COUNT, 12'd5, 12'd5, 1'b0);
    push_face(MODE_FINAL, 12'd5, 12'd5, 1'b0);
    push_face(MODE_COUNT, 12'd7, 12'd8, 1'b0);
    push_face(MODE_FINAL, 12'd7, 12'd7, 1'b1);
    push_face(MODE_FINAL, 12'd100, 12'd200, 1'b1);
    push_face(MODE_FINAL, 12'd300, 12'd301, 1'b0);
    push_face(MODE_COUNT, 12'd8, 12'd8, 1'b1);
    push_face(MODE_FINAL, 12'd8, 12'd9, 1'b1);
    push_face(MODE_COUNT, 12'hAAA, 12'h555, 1'b0);
    push_face(MODE_FINAL, 12'h555, 12'hAAA, 1'b1);
    push_face(MODE_FINAL, 12'd8, 12'd8, 1'b0);
    wait_sent();

    // Random part: mostly well-formed colour sets, some broken ones, some noise.
    n_queued = 0;
    while (n_queued < RANDOM_GOAL) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) queue_colour_set(1'b0);
      else if (pick < 17) queue_colour_set(1'b1);
      else push_face(1'($urandom_range(0, 1)), PT_W'($urandom_range(0, 4095)),
                     PT_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    end
    // Halfway through, hold the receiver off while the sender keeps offering.
    half = pending_faces.size() / 2;
    while (pending_faces.size() > half) @(posedge clk);
    hold_req = 1'b1;
    wait_sent();

    // Saturation of one point: drive its seen count to the top without a
    // degree, then its degree to the top, then finalise it.
    for (int k = 0; k < 128; k++) push_face(MODE_FINAL, HOT_POINT, HOT_POINT, 1'b0);
    for (int k = 0; k < 129; k++) push_face(MODE_COUNT, HOT_POINT, HOT_POINT, 1'b0);
    push_face(MODE_FINAL, HOT_POINT, HOT_POINT, 1'b1);
    wait_sent();

    // Drain: wait for every owed result, then let the block settle.
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", due_results.size()));

    $display("run: %0d faces taken (%0d replayed), %0d points finalised, %0d colour summaries",
             n_faces_in, n_replayed, n_points, n_summaries);
    $display("run: colour points reached %0d, colour number reached %0d, %0d errors",
             peak_cpts, peak_cnum, n_errors);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
